// ===== rtl/i2c_mbe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine package
// Phase, command and status codes, shared state and result types.
// ---------------------------------------------------------------------------
package i2c_mbe_pkg;

   localparam int unsigned TimeoutWidth = 16;
   localparam logic [TimeoutWidth-1:0] AckTimeoutReset = 16'd255;

   // sequencer phases
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_ST_CHECK  = 4'd1;
   localparam logic [3:0] PH_ST_LOW    = 4'd2;
   localparam logic [3:0] PH_SP_SCL    = 4'd3;
   localparam logic [3:0] PH_SP_SDA    = 4'd4;
   localparam logic [3:0] PH_WR_HIGH   = 4'd5;
   localparam logic [3:0] PH_WR_LOW    = 4'd6;
   localparam logic [3:0] PH_ACK_REL   = 4'd7;
   localparam logic [3:0] PH_ACK_HIGH  = 4'd8;
   localparam logic [3:0] PH_ACK_WAIT  = 4'd9;
   localparam logic [3:0] PH_RD_HIGH   = 4'd10;
   localparam logic [3:0] PH_RD_SAMPLE = 4'd11;
   localparam logic [3:0] PH_RD_GAP    = 4'd12;
   localparam logic [3:0] PH_AK_SDA    = 4'd13;
   localparam logic [3:0] PH_AK_HIGH   = 4'd14;
   localparam logic [3:0] PH_AK_LOW    = 4'd15;

   // commands
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_ACK   = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BUS_BUSY = 2'd1;
   localparam logic [1:0] ST_TIMEOUT  = 2'd2;

   // register index
   localparam logic REG_ACK_TIMEOUT = 1'b0;

   localparam logic [3:0] BitsPerByte = 4'd8;

   typedef struct packed {
      logic [3:0]              phase;
      logic [3:0]              bit_index;
      logic [7:0]              shift_byte;
      logic [TimeoutWidth-1:0] wait_count;
      logic [2:0]              current_op;
      logic                    ack_choice;
      logic                    scl_level;
      logic                    sda_level;
      logic [7:0]              rx_hold;
   } engine_state_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } engine_result_type;

endpackage

// ===== rtl/i2c_master_byte_engine_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine core
// Bit-level I2C master sequencer, one transfer in per bit-timing tick.
// ---------------------------------------------------------------------------
// Usage:
//   Each req transfer is one tick: a command (taken only while idle), the
//   write byte, the ack choice and the sampled SDA level. Each tick yields
//   exactly one rsp transfer with the SCL/SDA levels, busy, done, status and
//   the last read byte. SDA is open drain: sda_drive high means pull low.
//   rsp_tvalid rises in the cycle after the req transfer. Throughput is one
//   tick per cycle while the receiver takes each result; the sequencer state
//   register and the result register are the only stages, so ticks stream
//   back to back. The ack timeout register (address 0) resets to 255; the
//   user writes it through the csr port only while the engine is idle, and
//   the block does not enforce this. Reset returns the sequencer to idle
//   with both lines released high and empties the result register.
//   When the receiver stalls, the held result stays on rsp and req_tready
//   drops until it is taken; no tick is lost or repeated.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_core
   import i2c_mbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[2:0], data[10:3], ack_bit[11], sda_in[12], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], status[6:5],
   // read_data[14:7], zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   engine_state_type        state_ff;
   engine_state_type        state_in;
   engine_result_type       out_ff;
   engine_result_type       out_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   engine_state_type        step_nxt;
   engine_result_type       step_res;
   logic [TimeoutWidth-1:0] ack_timeout;
   logic                    req_xfer;

   i2c_mbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ack_timeout (ack_timeout)
   );

   i2c_mbe_step u_step (
      .cur         (state_ff),
      .cmd         (req_tdata[2:0]),
      .data        (req_tdata[10:3]),
      .ack_bit     (req_tdata[11]),
      .sda_in      (req_tdata[12]),
      .ack_timeout (ack_timeout),
      .nxt         (step_nxt),
      .res         (step_res)
   );

   assign req_tready = ~out_valid_ff | rsp_tready;
   assign req_xfer   = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (req_xfer) begin
         state_in     = step_nxt;
         out_in       = step_res;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.bit_index  <= 4'd0;
         state_ff.shift_byte <= 8'd0;
         state_ff.wait_count <= '0;
         state_ff.current_op <= OP_NONE;
         state_ff.ack_choice <= 1'b0;
         state_ff.scl_level  <= 1'b1;
         state_ff.sda_level  <= 1'b1;
         state_ff.rx_hold    <= 8'd0;
         out_valid_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.read_data, out_ff.status, out_ff.done_res,
                        out_ff.busy_res, out_ff.sda_drive, out_ff.sda_out, out_ff.scl};

   // error status only ever comes with done
   a_status_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.status != ST_OK) |-> out_ff.done_res)
      else $error("status set without done");

   // busy in the result matches the sequencer phase after that tick
   a_busy_phase : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (out_ff.busy_res == (state_ff.phase != PH_IDLE)))
      else $error("busy does not match phase");

   // the ack wait counter never runs past the timeout
   a_wait_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_ACK_WAIT) |-> (state_ff.wait_count <= ack_timeout))
      else $error("ack wait counter past timeout");

   // an idle tick without a command keeps the sequencer idle
   a_idle_tick : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && state_ff.phase == PH_IDLE && req_tdata[2:0] == OP_NONE)
      |=> (state_ff.phase == PH_IDLE))
      else $error("idle tick left idle");

   // an empty result register never blocks the input side
   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

// ===== rtl/i2c_mbe_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine register port
// APB-style access to the ack timeout register.
// ---------------------------------------------------------------------------
module i2c_mbe_csr
   import i2c_mbe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output logic [TimeoutWidth-1:0] ack_timeout
);

   logic [TimeoutWidth-1:0] ack_timeout_ff;
   logic [TimeoutWidth-1:0] ack_timeout_in;
   logic                    reg_sel;

   assign reg_sel    = (csr_paddr[2] == REG_ACK_TIMEOUT);
   assign csr_pready = 1'b1;

   always_comb begin
      ack_timeout_in = ack_timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         ack_timeout_in = csr_pwdata[TimeoutWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= AckTimeoutReset;
      end else begin
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   assign csr_prdata  = reg_sel ? {{(32-TimeoutWidth){1'b0}}, ack_timeout_ff} : 32'd0;
   assign ack_timeout = ack_timeout_ff;

endmodule

// ===== rtl/i2c_mbe_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine step logic
// Next state and line levels for one bit-timing tick.
// ---------------------------------------------------------------------------
module i2c_mbe_step
   import i2c_mbe_pkg::*;
(
   input  engine_state_type        cur,
   input  logic [2:0]              cmd,
   input  logic [7:0]              data,
   input  logic                    ack_bit,
   input  logic                    sda_in,
   input  logic [TimeoutWidth-1:0] ack_timeout,
   output engine_state_type        nxt,
   output engine_result_type       res
);

   logic       done;
   logic [1:0] status;
   logic [3:0] bit_next;

   assign bit_next = cur.bit_index + 4'd1;

   always_comb begin
      nxt    = cur;
      done   = 1'b0;
      status = ST_OK;
      case (cur.phase)
         PH_IDLE: begin
            nxt.current_op = OP_NONE;
            case (cmd)
               OP_START: begin
                  nxt.current_op = cmd;
                  nxt.sda_level  = 1'b1;
                  nxt.scl_level  = 1'b1;
                  nxt.phase      = PH_ST_CHECK;
               end
               OP_STOP: begin
                  nxt.current_op = cmd;
                  nxt.sda_level  = 1'b0;
                  nxt.phase      = PH_SP_SCL;
               end
               OP_WRITE: begin
                  nxt.current_op = cmd;
                  nxt.bit_index  = 4'd0;
                  nxt.scl_level  = 1'b0;
                  nxt.sda_level  = data[7];
                  nxt.shift_byte = {data[6:0], 1'b0};
                  nxt.phase      = PH_WR_HIGH;
               end
               OP_READ: begin
                  nxt.current_op = cmd;
                  nxt.ack_choice = ack_bit;
                  nxt.shift_byte = 8'd0;
                  nxt.bit_index  = 4'd0;
                  nxt.sda_level  = 1'b1;
                  nxt.phase      = PH_RD_HIGH;
               end
               OP_ACK: begin
                  nxt.current_op = cmd;
                  nxt.ack_choice = ack_bit;
                  nxt.sda_level  = ~ack_bit;
                  nxt.phase      = PH_AK_HIGH;
               end
               default: begin
               end
            endcase
         end
         PH_ST_CHECK: begin
            if (!sda_in) begin
               done      = 1'b1;
               status    = ST_BUS_BUSY;
               nxt.phase = PH_IDLE;
            end else begin
               nxt.sda_level = 1'b0;
               nxt.phase     = PH_ST_LOW;
            end
         end
         PH_ST_LOW: begin
            nxt.scl_level = 1'b0;
            done          = 1'b1;
            nxt.phase     = PH_IDLE;
         end
         PH_SP_SCL: begin
            nxt.scl_level = 1'b1;
            nxt.phase     = PH_SP_SDA;
         end
         PH_SP_SDA: begin
            nxt.sda_level = 1'b1;
            done          = 1'b1;
            // a stop that ends a write came from an ack timeout
            status        = (cur.current_op == OP_WRITE) ? ST_TIMEOUT : ST_OK;
            nxt.phase     = PH_IDLE;
         end
         PH_WR_HIGH: begin
            nxt.scl_level = 1'b1;
            nxt.bit_index = bit_next;
            nxt.phase     = (bit_next >= BitsPerByte) ? PH_ACK_REL : PH_WR_LOW;
         end
         PH_WR_LOW: begin
            nxt.scl_level  = 1'b0;
            nxt.sda_level  = cur.shift_byte[7];
            nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
            nxt.phase      = PH_WR_HIGH;
         end
         PH_ACK_REL: begin
            nxt.scl_level = 1'b0;
            nxt.sda_level = 1'b1;
            nxt.phase     = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            nxt.scl_level  = 1'b1;
            nxt.wait_count = '0;
            nxt.phase      = PH_ACK_WAIT;
         end
         PH_ACK_WAIT: begin
            if (!sda_in) begin
               nxt.scl_level = 1'b0;
               done          = 1'b1;
               nxt.phase     = PH_IDLE;
            end else if (cur.wait_count >= ack_timeout) begin
               nxt.sda_level = 1'b0;
               nxt.phase     = PH_SP_SCL;
            end else begin
               nxt.wait_count = cur.wait_count + 1'b1;
            end
         end
         PH_RD_HIGH: begin
            nxt.scl_level = 1'b1;
            nxt.phase     = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
            nxt.scl_level  = 1'b0;
            nxt.bit_index  = bit_next;
            nxt.phase      = (bit_next >= BitsPerByte) ? PH_AK_SDA : PH_RD_GAP;
         end
         PH_RD_GAP: begin
            nxt.phase = PH_RD_HIGH;
         end
         PH_AK_SDA: begin
            nxt.sda_level = ~cur.ack_choice;
            nxt.phase     = PH_AK_HIGH;
         end
         PH_AK_HIGH: begin
            nxt.scl_level = 1'b1;
            nxt.phase     = PH_AK_LOW;
         end
         PH_AK_LOW: begin
            nxt.scl_level = 1'b0;
            done          = 1'b1;
            if (cur.current_op == OP_READ) begin
               nxt.rx_hold = cur.shift_byte;
            end
            nxt.phase = PH_IDLE;
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res.scl       = nxt.scl_level;
      res.sda_out   = nxt.sda_level;
      res.sda_drive = ~nxt.sda_level;
      res.busy_res  = (nxt.phase != PH_IDLE);
      res.done_res  = done;
      res.status    = status;
      res.read_data = nxt.rx_hold;
   end

endmodule

// ===== tb/i2c_mbe_test_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine test package
// Tick and line-sample types, plus a scoreboard that mirrors the bit-level
// sequencer tick by tick and checks every returned line sample against it.
// ---------------------------------------------------------------------------
package i2c_mbe_test_pkg;
   import i2c_mbe_pkg::*;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data;
      logic       ack_bit;
      logic       sda_in;
   } bus_tick_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy;
      logic       done;
      logic [1:0] status;
      logic [7:0] read_data;
   } line_sample_type;

   class engine_shadow_type;
      logic [TimeoutWidth-1:0] ack_timeout;
      logic [3:0]              phase;
      logic [3:0]              bit_count;
      logic [7:0]              shift_reg;
      logic [TimeoutWidth-1:0] wait_count;
      logic [2:0]              op;
      logic                    ack_sel;
      logic                    scl;
      logic                    sda;
      logic [7:0]              rx_byte;
      line_sample_type         pending_samples[$];
      int                      errors;
      int                      samples_checked;

      function new();
         ack_timeout     = AckTimeoutReset;
         phase           = PH_IDLE;
         bit_count       = '0;
         shift_reg       = '0;
         wait_count      = '0;
         op              = OP_NONE;
         ack_sel         = 1'b0;
         scl             = 1'b1;
         sda             = 1'b1;
         rx_byte         = '0;
         errors          = 0;
         samples_checked = 0;
      endfunction

      // msb first onto sda
      function void shift_out();
         sda       = shift_reg[7];
         shift_reg = {shift_reg[6:0], 1'b0};
      endfunction

      // advance the sequencer by one accepted tick and queue the line sample
      function void note_tick(bus_tick_type t);
         line_sample_type s;
         logic            done;
         logic [1:0]      st;
         done = 1'b0;
         st   = ST_OK;
         case (phase)
            PH_IDLE: begin
               op = OP_NONE;
               case (t.cmd)
                  OP_START: begin
                     op = t.cmd; sda = 1'b1; scl = 1'b1; phase = PH_ST_CHECK;
                  end
                  OP_STOP: begin
                     op = t.cmd; sda = 1'b0; phase = PH_SP_SCL;
                  end
                  OP_WRITE: begin
                     op = t.cmd; shift_reg = t.data; bit_count = '0; scl = 1'b0;
                     shift_out();
                     phase = PH_WR_HIGH;
                  end
                  OP_READ: begin
                     op = t.cmd; ack_sel = t.ack_bit; shift_reg = '0; bit_count = '0;
                     sda = 1'b1; phase = PH_RD_HIGH;
                  end
                  OP_ACK: begin
                     op = t.cmd; ack_sel = t.ack_bit; sda = ~t.ack_bit;
                     phase = PH_AK_HIGH;
                  end
                  default: ;
               endcase
            end
            PH_ST_CHECK: begin
               if (!t.sda_in) begin
                  done = 1'b1; st = ST_BUS_BUSY; phase = PH_IDLE;
               end else begin
                  sda = 1'b0; phase = PH_ST_LOW;
               end
            end
            PH_ST_LOW: begin
               scl = 1'b0; done = 1'b1; phase = PH_IDLE;
            end
            PH_SP_SCL: begin
               scl = 1'b1; phase = PH_SP_SDA;
            end
            PH_SP_SDA: begin
               sda   = 1'b1;
               done  = 1'b1;
               // a stop run on behalf of a write is the timeout path
               st    = (op == OP_WRITE) ? ST_TIMEOUT : ST_OK;
               phase = PH_IDLE;
            end
            PH_WR_HIGH: begin
               scl       = 1'b1;
               bit_count = bit_count + 4'd1;
               phase     = (bit_count >= BitsPerByte) ? PH_ACK_REL : PH_WR_LOW;
            end
            PH_WR_LOW: begin
               scl = 1'b0;
               shift_out();
               phase = PH_WR_HIGH;
            end
            PH_ACK_REL: begin
               scl = 1'b0; sda = 1'b1; phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               scl = 1'b1; wait_count = '0; phase = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               if (!t.sda_in) begin
                  scl = 1'b0; done = 1'b1; phase = PH_IDLE;
               end else if (wait_count >= ack_timeout) begin
                  sda = 1'b0; phase = PH_SP_SCL;
               end else begin
                  wait_count = wait_count + 1'b1;
               end
            end
            PH_RD_HIGH: begin
               scl = 1'b1; phase = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
               shift_reg = {shift_reg[6:0], t.sda_in};
               scl       = 1'b0;
               bit_count = bit_count + 4'd1;
               phase     = (bit_count >= BitsPerByte) ? PH_AK_SDA : PH_RD_GAP;
            end
            PH_RD_GAP: phase = PH_RD_HIGH;
            PH_AK_SDA: begin
               sda = ~ack_sel; phase = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
               scl = 1'b1; phase = PH_AK_LOW;
            end
            default: begin
               scl  = 1'b0;
               done = 1'b1;
               if (op == OP_READ) rx_byte = shift_reg;
               phase = PH_IDLE;
            end
         endcase
         s.scl       = scl;
         s.sda_out   = sda;
         s.sda_drive = ~sda;
         s.busy      = (phase != PH_IDLE);
         s.done      = done;
         s.status    = st;
         s.read_data = rx_byte;
         pending_samples.push_back(s);
      endfunction

      task report(string what, int got, int wanted);
         errors++;
         $display("mismatch at sample %0d: %s got %0d, wanted %0d",
                  samples_checked, what, got, wanted);
      endtask

      // raw: scl[0], sda_out[1], sda_drive[2], busy[3], done[4], status[6:5],
      // read_data[14:7]
      task check_sample(logic [15:0] raw);
         line_sample_type w;
         if (pending_samples.size() == 0) begin
            report("sample with no tick pending", raw, 0);
         end else begin
            w = pending_samples.pop_front();
            if (raw[0] !== w.scl)            report("scl", raw[0], w.scl);
            if (raw[1] !== w.sda_out)        report("sda_out", raw[1], w.sda_out);
            if (raw[2] !== w.sda_drive)      report("sda_drive", raw[2], w.sda_drive);
            if (raw[3] !== w.busy)           report("busy", raw[3], w.busy);
            if (raw[4] !== w.done)           report("done", raw[4], w.done);
            if (raw[6:5] !== w.status)       report("status", raw[6:5], w.status);
            if (raw[14:7] !== w.read_data)   report("read_data", raw[14:7], w.read_data);
         end
         samples_checked++;
      endtask
   endclass

endpackage

// ===== tb/i2c_master_byte_engine_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c master byte engine core test
// Drives start, stop, write, read and ack sequences tick by tick with a
// simulated SDA line, under several ack timeout settings, and checks every
// line sample against a scoreboard that mirrors the sequencer.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_core_test;
   import i2c_mbe_pkg::*;
   import i2c_mbe_test_pkg::*;

   localparam int CycleLimit   = 2_000_000;
   localparam int RandomTicks  = 1100;
   localparam int SettleCycles = 4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // cmd[2:0], data[10:3], ack_bit[11], sda_in[12], zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], status[6:5],
   // read_data[14:7], zero
   logic [15:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   engine_shadow_type shadow;
   bit                quiet;
   int                ticks_sent;
   int                cycle_count;

   i2c_master_byte_engine_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_sample(rsp_tdata);
   end

   // receiver with random stall bursts
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 8);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = !reset;
         end
      end
   end

   // one tick transfer; called and returns at a falling edge
   task automatic send_tick(logic [2:0] c, logic [7:0] d, logic a, logic s);
      bus_tick_type t;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      t = '{cmd: c, data: d, ack_bit: a, sda_in: s};
      req_tdata  = {3'b000, s, a, d, c};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      shadow.note_tick(t);
      ticks_sent++;
      @(negedge clock);
   endtask

   // issue a command, then tick until the engine is idle again while playing
   // the slave side of SDA; ack_delay < 0 means the slave never acks
   task automatic transact(logic [2:0] c, logic [7:0] d, logic a, logic bus_free,
                           int ack_delay, logic [7:0] rd_byte, bit noisy);
      int         waited;
      int         rd_idx;
      logic       s;
      logic [2:0] nc;
      waited = 0;
      rd_idx = 0;
      send_tick(c, d, a, 1'($urandom_range(0, 1)));
      while (shadow.phase != PH_IDLE) begin
         s = 1'($urandom_range(0, 1));
         if (shadow.phase == PH_ST_CHECK) begin
            s = bus_free;
         end else if (shadow.phase == PH_ACK_WAIT) begin
            s = (ack_delay >= 0 && waited >= ack_delay) ? 1'b0 : 1'b1;
            waited++;
         end else if (shadow.phase == PH_RD_SAMPLE) begin
            s = rd_byte[7 - rd_idx];
            rd_idx++;
         end
         // commands sent mid-sequence must be ignored
         nc = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
         send_tick(nc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
      end
   endtask

   // hold off until every sample is back
   task automatic settle();
      req_tvalid = 1'b0;
      while (shadow.pending_samples.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_ack_timeout(logic [15:0] value);
      settle();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_ACK_TIMEOUT, 2'b00};
      csr_pwdata  = {16'h0000, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow.ack_timeout = value;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic int pick_ack_delay();
      return ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(0, 5));
   endfunction

   task automatic random_frame();
      int n;
      if ($urandom_range(0, 9) == 0) begin
         // stray or unknown command outside any frame
         transact(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_ack_delay(),
                  8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      if ($urandom_range(0, 9) != 0)
         transact(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7) != 0, 0, 8'h00, $urandom_range(0, 4) == 0);
      n = $urandom_range(1, 4);
      repeat (n) begin
         case ($urandom_range(0, 4))
            0, 1: transact(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'b1, pick_ack_delay(), 8'h00, $urandom_range(0, 4) == 0);
            2, 3: transact(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'b1, 0, 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            default: transact(OP_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b1, 0, 8'h00, $urandom_range(0, 4) == 0);
         endcase
      end
      if ($urandom_range(0, 9) != 0)
         transact(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b1, 0, 8'h00, $urandom_range(0, 4) == 0);
   endtask

   initial begin : stimulus
      int          target;
      int          guard;
      logic [15:0] tmo;
      shadow      = new();
      quiet       = 1'b0;
      ticks_sent  = 0;
      cycle_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed, reset timeout
      transact(OP_START, 8'h00, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_START, 8'h00, 1'b0, 1'b0, 0, 8'h00, 1'b0);   // bus busy
      transact(OP_WRITE, 8'hFF, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_WRITE, 8'h00, 1'b1, 1'b1, 3, 8'h00, 1'b1);   // commands while busy
      transact(OP_WRITE, 8'hA5, 1'b0, 1'b1, -1, 8'h00, 1'b0);  // ack timeout
      transact(OP_READ, 8'h00, 1'b1, 1'b1, 0, 8'hFF, 1'b0);
      transact(OP_READ, 8'hFF, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_READ, 8'h00, 1'b1, 1'b1, 0, 8'h5A, 1'b1);
      transact(OP_ACK, 8'h00, 1'b1, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_ACK, 8'h00, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_STOP, 8'h00, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(3'd6, 8'hFF, 1'b1, 1'b1, 0, 8'h00, 1'b0);       // unknown commands
      transact(3'd7, 8'h00, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      transact(OP_NONE, 8'h00, 1'b0, 1'b1, 0, 8'h00, 1'b0);

      // zero timeout: first high ack sample already times out
      write_ack_timeout(16'd0);
      transact(OP_WRITE, 8'h3C, 1'b0, 1'b1, -1, 8'h00, 1'b0);
      transact(OP_WRITE, 8'hC3, 1'b0, 1'b1, 0, 8'h00, 1'b0);
      write_ack_timeout(16'd1);
      transact(OP_WRITE, 8'h81, 1'b0, 1'b1, 1, 8'h00, 1'b0);
      transact(OP_WRITE, 8'h7E, 1'b0, 1'b1, -1, 8'h00, 1'b0);
      write_ack_timeout(16'hFFFF);
      transact(OP_WRITE, 8'h55, 1'b0, 1'b1, 100, 8'h00, 1'b0);
      transact(OP_WRITE, 8'hAA, 1'b0, 1'b1, 40, 8'h00, 1'b0);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       tmo = 16'($urandom_range(1, 64));
            1:       tmo = 16'd2;
            2:       tmo = 16'($urandom_range(1, 16));
            default: tmo = AckTimeoutReset;
         endcase
         write_ack_timeout(tmo);
         quiet  = (p == 3);
         target = ticks_sent + RandomTicks / 4;
         while (ticks_sent < target) begin
            random_frame();
            if ($urandom_range(0, 19) == 0) settle();
         end
      end
      req_tvalid = 1'b0;

      guard = 0;
      while (shadow.pending_samples.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      if (shadow.pending_samples.size() != 0)
         shadow.report("samples never returned", shadow.pending_samples.size(), 0);
      repeat (SettleCycles) @(posedge clock);
      if (shadow.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
